// ----- hw/rtl/lcabl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lcabl_pkg;

    localparam int NODE_W = 10;
    localparam int CNT_W  = 11;

    // Byte address bit that selects the register; only word 0 is decoded.
    localparam logic ADDR_NODE_COUNT = 1'b0;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNBUILT = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]        command;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] parent_node;
        logic              is_root;
        logic [NODE_W-1:0] other_node;
    } t_in_word;

    typedef struct packed {
        t_status           status;
        logic [NODE_W-1:0] ancestor;
    } t_out_word;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FIX_RD,
        S_FIX_WR,
        S_JMP_A,
        S_JMP_B,
        S_JMP_W,
        S_DEP_RD,
        S_DEP_WALK,
        S_Q_DEP,
        S_Q_LIFT,
        S_Q_LIFT_W,
        S_Q_CMP,
        S_Q_DESC,
        S_Q_DESC_W,
        S_Q_LAST,
        S_Q_FIN,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/lca_binary_lifting.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Lowest common ancestor engine using binary lifting. The ancestor table
// (LEVELS x MAX_NODES entries) and the depth table live in two synchronous
// memories with registered reads, each with two read ports and one write
// port, and a single sequencer works on one word at a time. A query does
// one ancestor lookup per lifting level and one paired lookup per descending
// level. A build fixes out-of-range parents, fills the higher ancestor levels
// and then finds each depth by walking parent links one a cycle. Results
// leave through an output register, so a new word is taken while one waits.
module lca_binary_lifting #(
    parameter int MAX_NODES = 1024,
    parameter int LEVELS    = 11
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire lcabl_pkg::t_in_word i_in_word,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output lcabl_pkg::t_out_word o_out_word,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [2:0]           paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int NW     = lcabl_pkg::NODE_W;
    localparam int CW     = lcabl_pkg::CNT_W;
    localparam int AW     = $clog2(MAX_NODES);
    localparam int JDEPTH = MAX_NODES * LEVELS;
    localparam int JAW    = $clog2(JDEPTH);
    localparam int LW     = $clog2(LEVELS);
    localparam logic [JAW-1:0] JSTRIDE  = JAW'(MAX_NODES);
    localparam logic [LW-1:0]  LVL_TOP  = LW'(LEVELS - 1);
    localparam logic [LW-1:0]  LVL_LAST = LW'(LEVELS - 2);

    function automatic logic [JAW-1:0] jaddr(input logic [LW-1:0] lvl,
                                             input logic [AW-1:0] nd);
        return JAW'(JAW'(lvl) * JSTRIDE) + JAW'(nd);
    endfunction

    logic [NW-1:0] r_jump_mem  [JDEPTH];
    logic [NW-1:0] r_depth_mem [MAX_NODES];

    lcabl_pkg::t_state    r_state, n_state;
    logic [CW-1:0]        r_node_count;
    logic                 r_built;
    logic                 r_out_valid;
    lcabl_pkg::t_out_word r_out;
    lcabl_pkg::t_out_word r_res;

    logic [CW-1:0] r_i;
    logic [LW-1:0] r_lvl;
    logic [NW-1:0] r_u, r_v, r_x, r_diff;
    logic [CW-1:0] r_d;
    logic [NW-1:0] r_jqa, r_jqb, r_dqa, r_dqb;

    logic [JAW-1:0] ja_addr, jb_addr, jw_addr;
    logic           jw_en;
    logic [NW-1:0]  jw_data;
    logic [AW-1:0]  da_addr, db_addr, dw_addr;
    logic           dw_en;
    logic [NW-1:0]  dw_data;

    logic [CW-1:0] cnt;
    logic          in_acc, cfg_wr, out_free;
    logic          last_node, walk_go, lift_bit;
    logic          load_bad, query_bad;
    logic [NW-1:0] diff_sh;
    lcabl_pkg::t_cmd cmd;

    assign cnt       = (32'(r_node_count) > MAX_NODES) ? CW'(MAX_NODES) : r_node_count;
    assign in_acc    = i_in_valid && o_in_ready;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign cmd       = lcabl_pkg::t_cmd'(i_in_word.command);
    assign last_node = (CW'(r_i + 1'b1) == cnt);
    assign walk_go   = (CW'(r_d + 1'b1) < cnt) && (r_jqa != r_x);
    assign diff_sh   = r_diff >> r_lvl;
    assign lift_bit  = diff_sh[0];
    assign load_bad  = ({1'b0, i_in_word.node} >= cnt) ||
                       (!i_in_word.is_root && ({1'b0, i_in_word.parent_node} >= cnt));
    assign query_bad = ({1'b0, i_in_word.node} >= cnt) ||
                       ({1'b0, i_in_word.other_node} >= cnt);

    assign o_in_ready  = (r_state == lcabl_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == lcabl_pkg::ADDR_NODE_COUNT) ?
                         32'(r_node_count) : 32'd0;

    always_ff @(posedge i_clk) begin
        r_jqa <= r_jump_mem[ja_addr];
        r_jqb <= r_jump_mem[jb_addr];
        if (jw_en) begin
            r_jump_mem[jw_addr] <= jw_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dqa <= r_depth_mem[da_addr];
        r_dqb <= r_depth_mem[db_addr];
        if (dw_en) begin
            r_depth_mem[dw_addr] <= dw_data;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lcabl_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (cmd)
                        lcabl_pkg::CMD_BUILD: begin
                            n_state = (cnt == '0) ? lcabl_pkg::S_OUT : lcabl_pkg::S_FIX_RD;
                        end
                        lcabl_pkg::CMD_QUERY: begin
                            n_state = (!r_built || query_bad) ?
                                      lcabl_pkg::S_OUT : lcabl_pkg::S_Q_DEP;
                        end
                        default: begin
                            n_state = lcabl_pkg::S_OUT;
                        end
                    endcase
                end
            end
            lcabl_pkg::S_FIX_RD: n_state = lcabl_pkg::S_FIX_WR;
            lcabl_pkg::S_FIX_WR: begin
                n_state = last_node ? lcabl_pkg::S_JMP_A : lcabl_pkg::S_FIX_RD;
            end
            lcabl_pkg::S_JMP_A: n_state = lcabl_pkg::S_JMP_B;
            lcabl_pkg::S_JMP_B: n_state = lcabl_pkg::S_JMP_W;
            lcabl_pkg::S_JMP_W: begin
                n_state = (last_node && r_lvl == LVL_LAST) ?
                          lcabl_pkg::S_DEP_RD : lcabl_pkg::S_JMP_A;
            end
            lcabl_pkg::S_DEP_RD: n_state = lcabl_pkg::S_DEP_WALK;
            lcabl_pkg::S_DEP_WALK: begin
                if (!walk_go) begin
                    n_state = last_node ? lcabl_pkg::S_OUT : lcabl_pkg::S_DEP_RD;
                end
            end
            lcabl_pkg::S_Q_DEP: n_state = lcabl_pkg::S_Q_LIFT;
            lcabl_pkg::S_Q_LIFT: begin
                if (lift_bit) begin
                    n_state = lcabl_pkg::S_Q_LIFT_W;
                end else if (r_lvl == LVL_TOP) begin
                    n_state = lcabl_pkg::S_Q_CMP;
                end
            end
            lcabl_pkg::S_Q_LIFT_W: begin
                n_state = (r_lvl == LVL_TOP) ? lcabl_pkg::S_Q_CMP : lcabl_pkg::S_Q_LIFT;
            end
            lcabl_pkg::S_Q_CMP: begin
                n_state = (r_u == r_v) ? lcabl_pkg::S_OUT : lcabl_pkg::S_Q_DESC;
            end
            lcabl_pkg::S_Q_DESC: n_state = lcabl_pkg::S_Q_DESC_W;
            lcabl_pkg::S_Q_DESC_W: begin
                n_state = (r_lvl == '0) ? lcabl_pkg::S_Q_LAST : lcabl_pkg::S_Q_DESC;
            end
            lcabl_pkg::S_Q_LAST: n_state = lcabl_pkg::S_Q_FIN;
            lcabl_pkg::S_Q_FIN: n_state = lcabl_pkg::S_OUT;
            lcabl_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = lcabl_pkg::S_IDLE;
                end
            end
            default: n_state = lcabl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        ja_addr = '0;
        jb_addr = '0;
        jw_addr = '0;
        jw_en   = 1'b0;
        jw_data = '0;
        da_addr = '0;
        db_addr = '0;
        dw_addr = AW'(r_i);
        dw_en   = 1'b0;
        dw_data = r_d[NW-1:0];
        case (r_state)
            lcabl_pkg::S_IDLE: begin
                da_addr = AW'(i_in_word.node);
                db_addr = AW'(i_in_word.other_node);
                jw_addr = jaddr('0, AW'(i_in_word.node));
                jw_data = i_in_word.is_root ? i_in_word.node : i_in_word.parent_node;
                jw_en   = in_acc && (cmd == lcabl_pkg::CMD_LOAD) && !load_bad;
            end
            lcabl_pkg::S_FIX_RD: ja_addr = jaddr('0, AW'(r_i));
            lcabl_pkg::S_FIX_WR: begin
                jw_addr = jaddr('0, AW'(r_i));
                jw_data = r_i[NW-1:0];
                jw_en   = ({1'b0, r_jqa} >= cnt);
            end
            lcabl_pkg::S_JMP_A: ja_addr = jaddr(r_lvl, AW'(r_i));
            lcabl_pkg::S_JMP_B: ja_addr = jaddr(r_lvl, AW'(r_jqa));
            lcabl_pkg::S_JMP_W: begin
                jw_addr = jaddr(LW'(r_lvl + 1'b1), AW'(r_i));
                jw_data = r_jqa;
                jw_en   = 1'b1;
            end
            lcabl_pkg::S_DEP_RD: ja_addr = jaddr('0, AW'(r_i));
            lcabl_pkg::S_DEP_WALK: begin
                ja_addr = jaddr('0, AW'(r_jqa));
                dw_en   = !walk_go;
            end
            lcabl_pkg::S_Q_LIFT: ja_addr = jaddr(r_lvl, AW'(r_u));
            lcabl_pkg::S_Q_DESC: begin
                ja_addr = jaddr(r_lvl, AW'(r_u));
                jb_addr = jaddr(r_lvl, AW'(r_v));
            end
            lcabl_pkg::S_Q_LAST: ja_addr = jaddr('0, AW'(r_u));
            default: begin
                ja_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lcabl_pkg::S_IDLE;
            r_node_count <= CW'(1);
            r_built      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr && paddr[2] == lcabl_pkg::ADDR_NODE_COUNT) begin
                r_node_count <= pwdata[CW-1:0];
                r_built      <= 1'b0;
            end else if (jw_en && r_state == lcabl_pkg::S_IDLE) begin
                r_built <= 1'b0;
            end else if (in_acc && cmd == lcabl_pkg::CMD_BUILD && cnt == '0) begin
                r_built <= 1'b1;
            end else if (r_state == lcabl_pkg::S_DEP_WALK && !walk_go && last_node) begin
                r_built <= 1'b1;
            end
            if (r_state == lcabl_pkg::S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            lcabl_pkg::S_IDLE: begin
                r_i   <= '0;
                r_lvl <= '0;
                r_u   <= i_in_word.node;
                r_v   <= i_in_word.other_node;
                r_res.ancestor <= '0;
                case (cmd)
                    lcabl_pkg::CMD_LOAD: begin
                        r_res.status <= load_bad ? lcabl_pkg::ST_RANGE : lcabl_pkg::ST_OK;
                    end
                    lcabl_pkg::CMD_QUERY: begin
                        if (!r_built) begin
                            r_res.status <= lcabl_pkg::ST_UNBUILT;
                        end else if (query_bad) begin
                            r_res.status <= lcabl_pkg::ST_RANGE;
                        end else begin
                            r_res.status <= lcabl_pkg::ST_OK;
                        end
                    end
                    default: begin
                        r_res.status <= lcabl_pkg::ST_OK;
                    end
                endcase
            end
            lcabl_pkg::S_FIX_WR: begin
                r_i <= last_node ? '0 : CW'(r_i + 1'b1);
            end
            lcabl_pkg::S_JMP_W: begin
                if (last_node) begin
                    r_i <= '0;
                    if (r_lvl != LVL_LAST) begin
                        r_lvl <= LW'(r_lvl + 1'b1);
                    end
                end else begin
                    r_i <= CW'(r_i + 1'b1);
                end
            end
            lcabl_pkg::S_DEP_RD: begin
                r_x <= r_i[NW-1:0];
                r_d <= '0;
            end
            lcabl_pkg::S_DEP_WALK: begin
                if (walk_go) begin
                    r_x <= r_jqa;
                    r_d <= CW'(r_d + 1'b1);
                end else begin
                    r_i <= CW'(r_i + 1'b1);
                end
            end
            lcabl_pkg::S_Q_DEP: begin
                r_lvl <= '0;
                if (r_dqa < r_dqb) begin
                    r_u    <= r_v;
                    r_v    <= r_u;
                    r_diff <= r_dqb - r_dqa;
                end else begin
                    r_diff <= r_dqa - r_dqb;
                end
            end
            lcabl_pkg::S_Q_LIFT: begin
                if (!lift_bit && r_lvl != LVL_TOP) begin
                    r_lvl <= LW'(r_lvl + 1'b1);
                end
            end
            lcabl_pkg::S_Q_LIFT_W: begin
                r_u <= r_jqa;
                if (r_lvl != LVL_TOP) begin
                    r_lvl <= LW'(r_lvl + 1'b1);
                end
            end
            lcabl_pkg::S_Q_CMP: begin
                r_lvl          <= LVL_TOP;
                r_res.ancestor <= r_u;
            end
            lcabl_pkg::S_Q_DESC_W: begin
                if (r_jqa != r_jqb) begin
                    r_u <= r_jqa;
                    r_v <= r_jqb;
                end
                if (r_lvl != '0) begin
                    r_lvl <= LW'(r_lvl - 1'b1);
                end
            end
            lcabl_pkg::S_Q_FIN: begin
                r_res.ancestor <= r_jqa;
            end
            lcabl_pkg::S_OUT: begin
                if (out_free) begin
                    r_out <= r_res;
                end
            end
            default: begin
                r_lvl <= r_lvl;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- tb/lca_binary_lifting_tb.sv -----
`timescale 1ns / 1ps

module lca_binary_lifting_tb;

    localparam int MAX_NODE_CNT = 1024;
    localparam int LIFT_LEVELS  = 11;
    localparam int SMALL_TREE   = 64;
    localparam int RAND_ITEMS   = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 200;
    localparam int DIR_ROWS     = 27;
    localparam int NW           = lcabl_pkg::NODE_W;
    localparam int CW           = lcabl_pkg::CNT_W;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int ROW_CFG     = 4;
    localparam int ROW_PREDICT = -1;

    typedef struct {
        int cmd;
        int nd;
        int par;
        int root;
        int oth;
        int exp_st;
        int exp_anc;
    } t_dir_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    lcabl_pkg::t_in_word  i_in_word   = '0;
    logic                 i_out_ready = 1'b0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [2:0]           paddr       = '0;
    logic [31:0]          pwdata      = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    lcabl_pkg::t_out_word o_out_word;
    logic [31:0]          prdata;
    logic                 pready;

    lca_binary_lifting u_top (.*);

    bit [NW-1:0] anc_tab [MAX_NODE_CNT][LIFT_LEVELS];
    bit [NW-1:0] dep_tab [MAX_NODE_CNT];
    bit          tables_ok = 1'b0;
    bit [CW-1:0] cnt_reg   = CW'(1);

    bit                   node_set [MAX_NODE_CNT];
    lcabl_pkg::t_out_word lca_expected [$];
    bit                   word_known  = 1'b0;
    lcabl_pkg::t_out_word word_expect = '0;
    int unsigned err_count   = 0;
    int unsigned rand_items  = 0;
    bit          counting    = 1'b0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned hold_ask     = 0;

    // Rows with an expected status of ROW_PREDICT are checked against the predictor.
    t_dir_row dir_tab [DIR_ROWS] = '{
        '{lcabl_pkg::CMD_QUERY,    0,    0, 0,    0, lcabl_pkg::ST_UNBUILT, 0},
        '{lcabl_pkg::CMD_LOAD,     0, 1023, 1,    0, lcabl_pkg::ST_OK,      0},
        '{lcabl_pkg::CMD_LOAD,     1,    0, 0,    0, lcabl_pkg::ST_RANGE,   0},
        '{CMD_NONE,             1023, 1023, 1, 1023, lcabl_pkg::ST_OK,      0},
        '{lcabl_pkg::CMD_BUILD,    0,    0, 0,    0, lcabl_pkg::ST_OK,      0},
        '{lcabl_pkg::CMD_QUERY,    0,    0, 0,    0, lcabl_pkg::ST_OK,      0},
        '{lcabl_pkg::CMD_QUERY, 1023,    0, 0,    0, lcabl_pkg::ST_RANGE,   0},
        '{ROW_CFG,                 8,    0, 0,    0, ROW_PREDICT,           0},
        '{lcabl_pkg::CMD_LOAD,     0,    0, 1,    0, lcabl_pkg::ST_OK,      0},
        '{lcabl_pkg::CMD_LOAD,     1,    0, 0,    0, lcabl_pkg::ST_OK,      0},
        '{lcabl_pkg::CMD_LOAD,     2,    0, 0,    0, lcabl_pkg::ST_OK,      0},
        '{lcabl_pkg::CMD_LOAD,     3,    1, 0,    0, lcabl_pkg::ST_OK,      0},
        '{lcabl_pkg::CMD_LOAD,     4,    1, 0,    0, lcabl_pkg::ST_OK,      0},
        '{lcabl_pkg::CMD_LOAD,     5,    3, 0,    0, lcabl_pkg::ST_OK,      0},
        '{lcabl_pkg::CMD_LOAD,     6,    2, 0,    0, lcabl_pkg::ST_OK,      0},
        '{lcabl_pkg::CMD_LOAD,     7,    7, 0,    0, lcabl_pkg::ST_OK,      0},
        '{lcabl_pkg::CMD_QUERY,    5,    0, 0,    4, lcabl_pkg::ST_UNBUILT, 0},
        '{lcabl_pkg::CMD_BUILD,    0,    0, 0,    0, lcabl_pkg::ST_OK,      0},
        '{lcabl_pkg::CMD_QUERY,    5,    0, 0,    4, ROW_PREDICT,           0},
        '{lcabl_pkg::CMD_QUERY,    3,    0, 0,    5, ROW_PREDICT,           0},
        '{lcabl_pkg::CMD_QUERY,    2,    0, 0,    8, lcabl_pkg::ST_RANGE,   0},
        '{ROW_CFG,                 3,    0, 0,    0, ROW_PREDICT,           0},
        '{lcabl_pkg::CMD_LOAD,     0,    1, 0,    0, lcabl_pkg::ST_OK,      0},
        '{lcabl_pkg::CMD_LOAD,     1,    2, 0,    0, lcabl_pkg::ST_OK,      0},
        '{lcabl_pkg::CMD_LOAD,     2,    0, 0,    0, lcabl_pkg::ST_OK,      0},
        '{lcabl_pkg::CMD_BUILD,    0,    0, 0,    0, lcabl_pkg::ST_OK,      0},
        '{lcabl_pkg::CMD_QUERY,    0,    0, 0,    2, ROW_PREDICT,           0}
    };

    function automatic int unsigned live_nodes();
        return (cnt_reg > MAX_NODE_CNT) ? MAX_NODE_CNT : cnt_reg;
    endfunction

    function automatic void build_lifting();
        int unsigned n, i, x, d;
        int j;
        n = live_nodes();
        for (i = 0; i < n; i++) begin
            if (anc_tab[i][0] >= n) begin
                anc_tab[i][0] = NW'(i);
            end
        end
        for (j = 1; j < LIFT_LEVELS; j++) begin
            for (i = 0; i < n; i++) begin
                anc_tab[i][j] = anc_tab[anc_tab[i][j-1]][j-1];
            end
        end
        // A cycle of parents stops the walk once the depth reaches n-1.
        for (i = 0; i < n; i++) begin
            x = i;
            d = 0;
            while (d + 1 < n && anc_tab[x][0] != x) begin
                x = anc_tab[x][0];
                d++;
            end
            dep_tab[i] = NW'(d);
        end
        tables_ok = 1'b1;
    endfunction

    function automatic logic [NW-1:0] lift_lca(int unsigned a, int unsigned b);
        int unsigned u, v, t, gap;
        int j;
        u = a;
        v = b;
        if (dep_tab[u] < dep_tab[v]) begin
            t = u;
            u = v;
            v = t;
        end
        gap = dep_tab[u] - dep_tab[v];
        for (j = 0; j < LIFT_LEVELS; j++) begin
            if (gap[j]) begin
                u = anc_tab[u][j];
            end
        end
        if (u == v) begin
            return NW'(u);
        end
        for (j = LIFT_LEVELS - 1; j >= 0; j--) begin
            if (anc_tab[u][j] != anc_tab[v][j]) begin
                u = anc_tab[u][j];
                v = anc_tab[v][j];
            end
        end
        return anc_tab[u][0];
    endfunction

    function automatic lcabl_pkg::t_out_word predict_lca(lcabl_pkg::t_in_word w);
        lcabl_pkg::t_out_word r;
        int unsigned n;
        n = live_nodes();
        r = '0;
        if (w.command == lcabl_pkg::CMD_LOAD) begin
            if (w.node >= n || (!w.is_root && w.parent_node >= n)) begin
                r.status = lcabl_pkg::ST_RANGE;
            end else begin
                anc_tab[w.node][0] = w.is_root ? w.node : w.parent_node;
                tables_ok = 1'b0;
            end
        end else if (w.command == lcabl_pkg::CMD_BUILD) begin
            build_lifting();
        end else if (w.command == lcabl_pkg::CMD_QUERY) begin
            if (!tables_ok) begin
                r.status = lcabl_pkg::ST_UNBUILT;
            end else if (w.node >= n || w.other_node >= n) begin
                r.status = lcabl_pkg::ST_RANGE;
            end else begin
                r.ancestor = lift_lca(w.node, w.other_node);
            end
        end
        return r;
    endfunction

    function automatic lcabl_pkg::t_in_word mk_word(logic [1:0] c, int unsigned nd,
                                                    int unsigned par, bit root,
                                                    int unsigned oth);
        lcabl_pkg::t_in_word w;
        w.command     = c;
        w.node        = NW'(nd);
        w.parent_node = NW'(par);
        w.is_root     = root;
        w.other_node  = NW'(oth);
        return w;
    endfunction

    task automatic send_word(input lcabl_pkg::t_in_word w, input bit known,
                             input lcabl_pkg::t_out_word res);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_in_word   <= w;
        word_known  <= known;
        word_expect <= res;
        if (w.command == lcabl_pkg::CMD_LOAD && w.node < live_nodes()
                && (w.is_root || w.parent_node < live_nodes())) begin
            node_set[w.node] = 1'b1;
        end
        if (counting && w.command != CMD_NONE) begin
            rand_items++;
        end
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (lca_expected.size() != 0);
    endtask

    task automatic write_count(input int unsigned value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {lcabl_pkg::ADDR_NODE_COUNT, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        cnt_reg   = CW'(value);
        tables_ok = 1'b0;
    endtask

    task automatic send_noise();
        int unsigned n, nd, par;
        n = live_nodes();
        case ($urandom_range(3))
            0: begin
                if (n < MAX_NODE_CNT && $urandom_range(1) == 0) begin
                    nd = $urandom_range(MAX_NODE_CNT - 1, n);
                    send_word(mk_word(lcabl_pkg::CMD_LOAD, nd, $urandom_range(1023),
                                      1'($urandom_range(1)), $urandom_range(1023)),
                              1'b0, '0);
                end else if (n < MAX_NODE_CNT) begin
                    par = $urandom_range(MAX_NODE_CNT - 1, n);
                    send_word(mk_word(lcabl_pkg::CMD_LOAD, $urandom_range(n - 1), par, 1'b0,
                                      $urandom_range(1023)), 1'b0, '0);
                end else begin
                    send_word(mk_word(CMD_NONE, $urandom_range(1023), $urandom_range(1023),
                                      1'($urandom_range(1)), $urandom_range(1023)),
                              1'b0, '0);
                end
            end
            1: begin
                send_word(mk_word(lcabl_pkg::CMD_QUERY, $urandom_range(1023),
                                  $urandom_range(1023), 1'($urandom_range(1)),
                                  $urandom_range(1023)), 1'b0, '0);
            end
            2: begin
                send_word(mk_word(CMD_NONE, $urandom_range(1023), $urandom_range(1023),
                                  1'($urandom_range(1)), $urandom_range(1023)), 1'b0, '0);
            end
            default: begin
                if (n <= SMALL_TREE) begin
                    send_word(mk_word(lcabl_pkg::CMD_LOAD, $urandom_range(n - 1),
                                      $urandom_range(n - 1), 1'b0, $urandom_range(1023)),
                              1'b0, '0);
                end else begin
                    send_word(mk_word(CMD_NONE, 0, 0, 1'b0, 0), 1'b0, '0);
                end
            end
        endcase
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin : sink
        int unsigned hold_left, hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_ask) begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        lcabl_pkg::t_out_word want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                want = predict_lca(i_in_word);
                lca_expected = {lca_expected, (word_known ? word_expect : want)};
            end
            if (o_out_valid && i_out_ready) begin
                if (lca_expected.size() == 0) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("unexpected result word: status %0d ancestor %0d",
                                 o_out_word.status, o_out_word.ancestor);
                    end
                end else begin
                    want = lca_expected.pop_front();
                    if (o_out_word.status !== want.status
                            || o_out_word.ancestor !== want.ancestor) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("mismatch: status %0d ancestor %0d, expected %0d and %0d",
                                     o_out_word.status, o_out_word.ancestor,
                                     want.status, want.ancestor);
                        end
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int unsigned n, k, i, j, t, par, nd, oth, roll, q, chain_pct, phase_no;
        bit full, root;
        int unsigned order [MAX_NODE_CNT];
        lcabl_pkg::t_out_word known_res;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            if (dir_tab[r].cmd == ROW_CFG) begin
                write_count(dir_tab[r].nd);
            end else begin
                known_res.status   = lcabl_pkg::t_status'(dir_tab[r].exp_st);
                known_res.ancestor = NW'(dir_tab[r].exp_anc);
                send_word(mk_word(2'(dir_tab[r].cmd), dir_tab[r].nd, dir_tab[r].par,
                                  dir_tab[r].root != 0, dir_tab[r].oth),
                          dir_tab[r].exp_st != ROW_PREDICT, known_res);
            end
        end

        counting = 1'b1;
        phase_no = 0;
        while (rand_items < RAND_ITEMS) begin
            if (rand_items < RAND_ITEMS / 3) begin
                src_idle_pct = 22;
                snk_idle_pct = 45;
            end else if (rand_items < 2 * RAND_ITEMS / 3) begin
                src_idle_pct = 45;
                snk_idle_pct = 22;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            if (phase_no == 2) begin
                n = MAX_NODE_CNT;
            end else if ($urandom_range(9) == 0) begin
                n = 1;
            end else begin
                n = $urandom_range(48, 2);
            end
            if (n != live_nodes() || $urandom_range(3) == 0) begin
                write_count(n);
            end

            // Every node in use must hold a parent before the tables are built.
            full = ($urandom_range(3) != 0);
            for (i = 0; i < n; i++) begin
                if (!node_set[i]) begin
                    full = 1'b1;
                end
            end
            if (full) begin
                for (i = 0; i < n; i++) begin
                    order[i] = i;
                end
                for (i = n - 1; i > 0; i--) begin
                    j = $urandom_range(i);
                    t = order[i];
                    order[i] = order[j];
                    order[j] = t;
                end
                chain_pct = (n > SMALL_TREE) ? 0 : 45 * $urandom_range(2);
                for (k = 0; k < n; k++) begin
                    root = (k == 0) || (n <= SMALL_TREE && $urandom_range(19) == 0);
                    if (root) begin
                        par = $urandom_range(MAX_NODE_CNT - 1);
                    end else if ($urandom_range(99) < chain_pct) begin
                        par = order[k - 1];
                    end else begin
                        par = order[$urandom_range(k - 1)];
                    end
                    send_word(mk_word(lcabl_pkg::CMD_LOAD, order[k], par, root,
                                      $urandom_range(1023)), 1'b0, '0);
                end
            end else begin
                repeat ($urandom_range(2)) begin
                    send_word(mk_word(lcabl_pkg::CMD_LOAD, $urandom_range(n - 1),
                                      $urandom_range(n - 1), 1'b0, $urandom_range(1023)),
                              1'b0, '0);
                end
            end

            repeat ($urandom_range(3)) send_noise();
            send_word(mk_word(lcabl_pkg::CMD_BUILD, $urandom_range(1023), $urandom_range(1023),
                              1'($urandom_range(1)), $urandom_range(1023)), 1'b0, '0);

            if (phase_no == 1) begin
                hold_ask++;
            end
            q = $urandom_range(60, 15);
            repeat (q) begin
                roll = $urandom_range(99);
                if (roll < 8 && n < MAX_NODE_CNT) begin
                    nd  = $urandom_range(MAX_NODE_CNT - 1, n);
                    oth = $urandom_range(1023);
                    if ($urandom_range(1) == 0) begin
                        t = nd;
                        nd = oth;
                        oth = t;
                    end
                    send_word(mk_word(lcabl_pkg::CMD_QUERY, nd, $urandom_range(1023),
                                      1'($urandom_range(1)), oth), 1'b0, '0);
                end else if (roll < 12 && n <= SMALL_TREE) begin
                    send_word(mk_word(lcabl_pkg::CMD_BUILD, $urandom_range(1023),
                                      $urandom_range(1023), 1'($urandom_range(1)),
                                      $urandom_range(1023)), 1'b0, '0);
                end else if (roll < 18) begin
                    send_noise();
                end else begin
                    send_word(mk_word(lcabl_pkg::CMD_QUERY, $urandom_range(n - 1),
                                      $urandom_range(1023), 1'($urandom_range(1)),
                                      $urandom_range(n - 1)), 1'b0, '0);
                end
            end
            if ($urandom_range(1) == 0) begin
                wait_drained();
            end
            phase_no++;
        end

        counting = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
